[rtl/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, codes and types of the sector allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int TRK_W      = 8;
  localparam int SEC_W      = 8;
  localparam int SECT_W     = 5;
  localparam int CNT_W      = 8;
  localparam int LBM_W      = 24;
  localparam int STAT_W     = 3;
  localparam int FUNC_W     = 2;
  localparam int NTRK_W     = 7;
  localparam int MCNT_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_LOAD  = 2'd2
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ALLOC    = 3'd0,
    ST_FULL     = 3'd1,
    ST_FREED    = 3'd2,
    ST_IGNORED  = 3'd3,
    ST_LOADED   = 3'd4,
    ST_REJECTED = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_TRACKS = 3'd0,
    CFG_DIR_TRACK  = 3'd1,
    CFG_DIR_SECTOR = 3'd2,
    CFG_MAP_COUNT  = 3'd3,
    CFG_MAP0_TRACK = 3'd4,
    CFG_MAP0_SEC   = 3'd5,
    CFG_MAP1_TRACK = 3'd6,
    CFG_MAP1_SEC   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TRK_W-1:0] dir_trk;
    logic [SEC_W-1:0] dir_sec;
    logic             map0_en;
    logic [TRK_W-1:0] map0_trk;
    logic [SEC_W-1:0] map0_sec;
    logic             map1_en;
    logic [TRK_W-1:0] map1_trk;
    logic [SEC_W-1:0] map1_sec;
  } excl_t;

endpackage

[rtl/bsa_if.sv]
// ----------------------------------------------------------------------------
// bsa_in_if / bsa_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface bsa_in_if import bsa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TRK_W-1:0]  trk;
  logic [SEC_W-1:0]  sec;
  logic [SECT_W-1:0] load_sectors;
  logic [CNT_W-1:0]  load_free_count;
  logic [LBM_W-1:0]  load_bitmap;

  modport source (output valid, func, trk, sec, load_sectors, load_free_count, load_bitmap,
                  input ready);
  modport sink (input valid, func, trk, sec, load_sectors, load_free_count, load_bitmap,
                output ready);
endinterface

interface bsa_out_if import bsa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [TRK_W-1:0]  got_track;
  logic [SECT_W-1:0] got_sector;

  modport source (output valid, status, got_track, got_sector, input ready);
  modport sink (input valid, status, got_track, got_sector, output ready);
endinterface

[rtl/bsa_store.sv]
// ----------------------------------------------------------------------------
// bsa_store
// Track entry memory, one read and one write port, registered read data.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module bsa_store #(
  parameter int DEPTH  = 70,
  parameter int DATA_W = 37
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[rtl/bsa_pick.sv]
// ----------------------------------------------------------------------------
// bsa_pick
// Exclusion mask of one track and lowest free, allocatable sector.
// ----------------------------------------------------------------------------
module bsa_pick import bsa_pkg::*; #(
  parameter int BITS = 24
) (
  input  logic [TRK_W-1:0]  trk,
  input  logic [SECT_W-1:0] sectors,
  input  logic [BITS-1:0]   bits,
  input  excl_t             excl,
  output logic [BITS-1:0]   excl_mask,
  output logic              found,
  output logic [BITS-1:0]   pick_oh,
  output logic [SECT_W-1:0] pick_sec
);

  logic [BITS-1:0] below;
  logic [BITS-1:0] avail;

  always_comb begin
    for (int s = 0; s < BITS; s++) begin
      excl_mask[s] = (excl.dir_trk == trk && excl.dir_sec == SEC_W'(s)) ||
                     (excl.map0_en && excl.map0_trk == trk && excl.map0_sec == SEC_W'(s)) ||
                     (excl.map1_en && excl.map1_trk == trk && excl.map1_sec == SEC_W'(s));
      below[s]     = (SECT_W'(s) < sectors);
    end
  end

  assign avail   = bits & below & ~excl_mask;
  assign found   = |avail;
  assign pick_oh = avail & (~avail + BITS'(1));

  always_comb begin
    pick_sec = '0;
    for (int s = 0; s < BITS; s++) begin
      if (pick_oh[s]) begin
        pick_sec = pick_sec | SECT_W'(s);
      end
    end
  end

endmodule

[rtl/bam_sector_allocator.sv]
// ----------------------------------------------------------------------------
// bam_sector_allocator
// Block-availability map with first-fit sector allocation over a track store.
//
//   channel | dir | handshake       | word
//   in_ch   | in  | valid/ready     | func, trk, sec, load_sectors, load_free_count, load_bitmap
//   out_ch  | out | valid/ready     | status, got_track, got_sector
//   cfg_*   | in  | cfg_we          | cfg_idx, cfg_wdata
//
// Load, rejected and ignored words pass through S_DONE to the output register,
// an in-range free through S_FREE and then S_DONE.
// Alloc reads one track entry per cycle from the store in S_SCAN.
// One word is in work at a time; the next is accepted while a result waits.
// Reset clears the store valid bits at once; no sweep is needed.
// A stalled output holds the finished result; the next result waits for it.
// ----------------------------------------------------------------------------
module bam_sector_allocator import bsa_pkg::*; #(
  parameter int MAX_TRACKS = 70,
  parameter int MAP_BYTES  = 3,
  parameter int MAX_MAPS   = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bsa_in_if.sink                in_ch,
  bsa_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BITS  = 8 * MAP_BYTES;
  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int ENT_W = SECT_W + CNT_W + BITS;
  localparam logic [TRK_W-1:0] MAX_T = TRK_W'(MAX_TRACKS);
  localparam logic [2:0]       MAX_M = 3'(MAX_MAPS);
  localparam logic [SEC_W-1:0] BITS_S = SEC_W'(BITS);

  typedef enum logic [1:0] {S_IDLE, S_FREE, S_SCAN, S_DONE} state_t;

  state_t state_r, state_nxt;

  logic [NTRK_W-1:0] num_tracks_r;
  logic [TRK_W-1:0]  dir_track_r;
  logic [SEC_W-1:0]  dir_sector_r;
  logic [MCNT_W-1:0] map_count_r;
  logic [TRK_W-1:0]  map0_track_r;
  logic [SEC_W-1:0]  map0_sector_r;
  logic [TRK_W-1:0]  map1_track_r;
  logic [SEC_W-1:0]  map1_sector_r;

  logic [TRK_W-1:0]  t_r, t_nxt;
  logic [TRK_W-1:0]  trk_r, trk_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  status_t           res_stat_r, res_stat_nxt;
  logic [TRK_W-1:0]  res_trk_r, res_trk_nxt;
  logic [SECT_W-1:0] res_sec_r, res_sec_nxt;

  logic              out_valid_r;
  status_t           out_stat_r;
  logic [TRK_W-1:0]  out_trk_r;
  logic [SECT_W-1:0] out_sec_r;

  logic [TRK_W-1:0]  n_eff;
  logic [2:0]        m_eff;
  logic              usable;
  excl_t             excl;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [ENT_W-1:0]  rd_data, wr_data;

  logic [SECT_W-1:0] ent_sect;
  logic [CNT_W-1:0]  ent_cnt;
  logic [BITS-1:0]   ent_bits;

  logic [TRK_W-1:0]  pick_trk;
  logic [BITS-1:0]   excl_mask, pick_oh, sec_oh;
  logic              pick_found;
  logic [SECT_W-1:0] pick_sec;

  logic [TRK_W-1:0]  in_dec, trk_dec, t_dec;
  logic              free_in_ok, load_ok, free_do, out_free;

  // effective geometry
  assign n_eff  = ({1'b0, num_tracks_r} > MAX_T) ? MAX_T : {1'b0, num_tracks_r};
  assign m_eff  = ({1'b0, map_count_r} > MAX_M) ? MAX_M : {1'b0, map_count_r};
  assign usable = (m_eff != 3'd0) && (n_eff != '0) && (n_eff >= {5'd0, m_eff});

  assign excl.dir_trk  = dir_track_r;
  assign excl.dir_sec  = dir_sector_r;
  assign excl.map0_en  = (m_eff >= 3'd1);
  assign excl.map0_trk = map0_track_r;
  assign excl.map0_sec = map0_sector_r;
  assign excl.map1_en  = (m_eff >= 3'd2);
  assign excl.map1_trk = map1_track_r;
  assign excl.map1_sec = map1_sector_r;

  assign ent_sect = rd_data[ENT_W-1 -: SECT_W];
  assign ent_cnt  = rd_data[BITS +: CNT_W];
  assign ent_bits = rd_data[BITS-1:0];

  assign in_dec  = in_ch.trk - TRK_W'(1);
  assign trk_dec = trk_r - TRK_W'(1);
  assign t_dec   = t_r - TRK_W'(1);

  assign free_in_ok = usable && (in_ch.trk != '0) && (in_ch.trk <= n_eff);
  assign load_ok    = (in_ch.trk != '0) && (in_ch.trk <= MAX_T) &&
                      ({3'd0, in_ch.load_sectors} <= BITS_S);

  always_comb begin
    for (int s = 0; s < BITS; s++) begin
      sec_oh[s] = (sec_r == SEC_W'(s));
    end
  end

  assign free_do = (sec_r < {3'd0, ent_sect}) && (|sec_oh) && !(|(sec_oh & excl_mask)) &&
                   !(|(sec_oh & ent_bits));

  assign pick_trk = (state_r == S_FREE) ? trk_r : t_r;
  assign out_free = !out_valid_r || out_ch.ready;

  bsa_pick #(.BITS(BITS)) u_pick (
    .trk       (pick_trk),
    .sectors   (ent_sect),
    .bits      (ent_bits),
    .excl      (excl),
    .excl_mask (excl_mask),
    .found     (pick_found),
    .pick_oh   (pick_oh),
    .pick_sec  (pick_sec)
  );

  bsa_store #(.DEPTH(MAX_TRACKS), .DATA_W(ENT_W)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    state_nxt    = state_r;
    t_nxt        = t_r;
    trk_nxt      = trk_r;
    sec_nxt      = sec_r;
    res_stat_nxt = res_stat_r;
    res_trk_nxt  = res_trk_r;
    res_sec_nxt  = res_sec_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          trk_nxt      = in_ch.trk;
          sec_nxt      = in_ch.sec;
          res_trk_nxt  = '0;
          res_sec_nxt  = '0;
          res_stat_nxt = ST_IGNORED;
          state_nxt    = S_DONE;
          case (func_t'(in_ch.func))
            FN_ALLOC: begin
              if (usable) begin
                rd_en     = 1'b1;
                t_nxt     = TRK_W'(1);
                state_nxt = S_SCAN;
              end else begin
                res_stat_nxt = ST_FULL;
              end
            end
            FN_FREE: begin
              if (free_in_ok) begin
                rd_en     = 1'b1;
                rd_addr   = in_dec[IDX_W-1:0];
                state_nxt = S_FREE;
              end
            end
            FN_LOAD: begin
              if (load_ok) begin
                wr_en        = 1'b1;
                wr_addr      = in_dec[IDX_W-1:0];
                wr_data      = {in_ch.load_sectors, in_ch.load_free_count,
                                in_ch.load_bitmap[BITS-1:0]};
                res_stat_nxt = ST_LOADED;
              end else begin
                res_stat_nxt = ST_REJECTED;
              end
            end
            default: ;
          endcase
        end
      end
      S_FREE: begin
        state_nxt = S_DONE;
        if (free_do) begin
          wr_en        = 1'b1;
          wr_addr      = trk_dec[IDX_W-1:0];
          wr_data      = {ent_sect, ent_cnt + CNT_W'(1), ent_bits | sec_oh};
          res_stat_nxt = ST_FREED;
        end
      end
      S_SCAN: begin
        if (ent_cnt != '0 && pick_found) begin
          wr_en        = 1'b1;
          wr_addr      = t_dec[IDX_W-1:0];
          wr_data      = {ent_sect, ent_cnt - CNT_W'(1), ent_bits & ~pick_oh};
          res_stat_nxt = ST_ALLOC;
          res_trk_nxt  = t_r;
          res_sec_nxt  = pick_sec;
          state_nxt    = S_DONE;
        end else if (t_r >= n_eff) begin
          res_stat_nxt = ST_FULL;
          state_nxt    = S_DONE;
        end else begin
          // advance to the next track
          rd_en   = 1'b1;
          rd_addr = t_r[IDX_W-1:0];
          t_nxt   = t_r + TRK_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      num_tracks_r  <= NTRK_W'(35);
      dir_track_r   <= TRK_W'(18);
      dir_sector_r  <= SEC_W'(1);
      map_count_r   <= MCNT_W'(1);
      map0_track_r  <= TRK_W'(18);
      map0_sector_r <= '0;
      map1_track_r  <= TRK_W'(53);
      map1_sector_r <= '0;
    end else begin
      state_r      <= state_nxt;
      t_r          <= t_nxt;
      trk_r        <= trk_nxt;
      sec_r        <= sec_nxt;
      res_stat_r   <= res_stat_nxt;
      res_trk_r    <= res_trk_nxt;
      res_sec_r    <= res_sec_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        out_stat_r  <= res_stat_r;
        out_trk_r   <= res_trk_r;
        out_sec_r   <= res_sec_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_NUM_TRACKS: num_tracks_r  <= cfg_wdata[NTRK_W-1:0];
          CFG_DIR_TRACK:  dir_track_r   <= cfg_wdata;
          CFG_DIR_SECTOR: dir_sector_r  <= cfg_wdata;
          CFG_MAP_COUNT:  map_count_r   <= cfg_wdata[MCNT_W-1:0];
          CFG_MAP0_TRACK: map0_track_r  <= cfg_wdata;
          CFG_MAP0_SEC:   map0_sector_r <= cfg_wdata;
          CFG_MAP1_TRACK: map1_track_r  <= cfg_wdata;
          CFG_MAP1_SEC:   map1_sector_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_stat_r;
  assign out_ch.got_track  = out_trk_r;
  assign out_ch.got_sector = out_sec_r;

  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n) !(rd_en && wr_en))
    else $error("store read and write in the same cycle");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (t_r != '0 && t_r <= n_eff))
    else $error("scan track out of range");

  a_alloc_trk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == ST_ALLOC) |-> (out_trk_r != '0))
    else $error("allocated track zero");

  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != ST_ALLOC) |-> (out_trk_r == '0 && out_sec_r == '0))
    else $error("address on a non-alloc result");

  a_no_wr_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !wr_en && !rd_en)
    else $error("store access while result pending");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sector allocator. Load, alloc and free words are
// sent under several disk geometries, with random gaps and output stalls, and
// every result is checked against a shadow copy of the availability map.
// ----------------------------------------------------------------------------
import bsa_pkg::*;

localparam int TRACKS   = 70;
localparam int SPT      = 24;
localparam int MAPS_MAX = 2;

localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

typedef struct {
  logic [FUNC_W-1:0] func;
  logic [TRK_W-1:0]  trk;
  logic [SEC_W-1:0]  sec;
  logic [SECT_W-1:0] nsec;
  logic [CNT_W-1:0]  fcnt;
  logic [LBM_W-1:0]  bmap;
} bam_req_t;

typedef struct {
  status_t           status;
  logic [TRK_W-1:0]  trk;
  logic [SECT_W-1:0] sec;
} bam_rsp_t;

typedef struct {
  logic [TRK_W-1:0] trk;
  logic [SEC_W-1:0] sec;
} sec_addr_t;

class bam_shadow_map;
  logic [NTRK_W-1:0] n_trk;
  logic [MCNT_W-1:0] n_map;
  logic [TRK_W-1:0]  d_trk, m0_trk, m1_trk;
  logic [SEC_W-1:0]  d_sec, m0_sec, m1_sec;
  logic [SECT_W-1:0] sectors   [TRACKS];
  logic [CNT_W-1:0]  free_cnt  [TRACKS];
  logic [LBM_W-1:0]  free_bits [TRACKS];
  bam_rsp_t          due[$];
  sec_addr_t         held[$];
  int                faults;

  function new();
    n_trk = 35; d_trk = 18; d_sec = 1; n_map = 1;
    m0_trk = 18; m0_sec = 0; m1_trk = 53; m1_sec = 0;
    foreach (sectors[i]) begin
      sectors[i] = '0;
      free_cnt[i] = '0;
      free_bits[i] = '0;
    end
    faults = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_NUM_TRACKS: n_trk = v[NTRK_W-1:0];
      CFG_DIR_TRACK:  d_trk = v;
      CFG_DIR_SECTOR: d_sec = v;
      CFG_MAP_COUNT:  n_map = v[MCNT_W-1:0];
      CFG_MAP0_TRACK: m0_trk = v;
      CFG_MAP0_SEC:   m0_sec = v;
      CFG_MAP1_TRACK: m1_trk = v;
      CFG_MAP1_SEC:   m1_sec = v;
      default: ;
    endcase
  endfunction

  function int tracks_in_use();
    return (n_trk > TRACKS) ? TRACKS : int'(n_trk);
  endfunction

  function int maps_in_use();
    return (n_map > MAPS_MAX) ? MAPS_MAX : int'(n_map);
  endfunction

  function bit map_ok();
    int m, t;
    m = maps_in_use();
    t = tracks_in_use();
    return m != 0 && t != 0 && t >= m;
  endfunction

  function bit is_system_sector(int t, int s);
    int m;
    m = maps_in_use();
    if (t == d_trk && s == d_sec) return 1'b1;
    if (m >= 1 && t == m0_trk && s == m0_sec) return 1'b1;
    if (m >= 2 && t == m1_trk && s == m1_sec) return 1'b1;
    return 1'b0;
  endfunction

  function void note_request(bam_req_t r);
    bam_rsp_t  x;
    sec_addr_t a;
    int        t, s, i;
    bit        found;
    x.status = ST_IGNORED;
    x.trk = '0;
    x.sec = '0;
    found = 1'b0;
    case (r.func)
      FN_ALLOC: begin
        x.status = ST_FULL;
        if (map_ok()) begin
          for (t = 1; t <= tracks_in_use() && !found; t++) begin
            i = t - 1;
            if (free_cnt[i] != 0) begin
              for (s = 0; s < SPT && s < sectors[i] && !found; s++) begin
                if (free_bits[i][s] && !is_system_sector(t, s)) begin
                  free_bits[i][s] = 1'b0;
                  free_cnt[i] = free_cnt[i] - 8'd1;
                  x.status = ST_ALLOC;
                  x.trk = t[TRK_W-1:0];
                  x.sec = s[SECT_W-1:0];
                  a.trk = t[TRK_W-1:0];
                  a.sec = s[SEC_W-1:0];
                  held = {held, a};
                  found = 1'b1;
                end
              end
            end
          end
        end
      end
      FN_FREE: begin
        if (map_ok() && r.trk >= 1 && r.trk <= tracks_in_use()) begin
          i = r.trk - 1;
          if (r.sec < sectors[i] && r.sec < SPT && !is_system_sector(r.trk, r.sec)) begin
            if (!free_bits[i][r.sec]) begin
              free_bits[i][r.sec] = 1'b1;
              free_cnt[i] = free_cnt[i] + 8'd1;
              x.status = ST_FREED;
            end
          end
        end
      end
      FN_LOAD: begin
        x.status = ST_REJECTED;
        if (r.trk >= 1 && r.trk <= TRACKS && r.nsec <= SPT) begin
          i = r.trk - 1;
          sectors[i] = r.nsec;
          free_cnt[i] = r.fcnt;
          free_bits[i] = r.bmap;
          x.status = ST_LOADED;
        end
      end
      default: ;
    endcase
    due = {due, x};
  endfunction

  function void report(string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endfunction

  function void check_result(logic [STAT_W-1:0] st, logic [TRK_W-1:0] gt,
                             logic [SECT_W-1:0] gs);
    bam_rsp_t x;
    if (due.size() == 0) begin
      report($sformatf("unexpected word: status %0d track %0d sector %0d", st, gt, gs));
      return;
    end
    x = due.pop_front();
    if (st !== x.status || gt !== x.trk || gs !== x.sec)
      report($sformatf("expected status %0d track %0d sector %0d, got %0d %0d %0d",
                       x.status, x.trk, x.sec, st, gt, gs));
  endfunction
endclass

module tb;
  localparam int ITEMS       = 1550;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL        = 150;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bsa_in_if  in_ch();
  bsa_out_if out_ch();

  bam_shadow_map book;
  int            sent = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;
  int            quiet_cycles = 0;

  bam_sector_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(99, 0) < stall_pct) begin
        stall_left = $urandom_range(14, 0);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      book.check_result(out_ch.status, out_ch.got_track, out_ch.got_sector);
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input int fn, input int tk, input int sc, input int ns,
                           input int fc, input int bm);
    bam_req_t r;
    r.func = fn[FUNC_W-1:0];
    r.trk  = tk[TRK_W-1:0];
    r.sec  = sc[SEC_W-1:0];
    r.nsec = ns[SECT_W-1:0];
    r.fcnt = fc[CNT_W-1:0];
    r.bmap = bm[LBM_W-1:0];
    if ($urandom_range(99, 0) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= r.func;
    in_ch.trk             <= r.trk;
    in_ch.sec             <= r.sec;
    in_ch.load_sectors    <= r.nsec;
    in_ch.load_free_count <= r.fcnt;
    in_ch.load_bitmap     <= r.bmap;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.note_request(r);
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v[CFG_DATA_W-1:0];
    book.set_reg(idx, v[CFG_DATA_W-1:0]);
  endtask

  task automatic set_geometry(input int p);
    int v[8];
    int ef;
    drain_results();
    case (p)
      0: v = '{35, 18, 1, 1, 18, 0, 53, 0};
      1: v = '{70, 18, 1, 2, 18, 0, 53, 0};
      2: v = '{0, 18, 1, 1, 18, 0, 53, 0};
      3: v = '{127, 255, 255, 3, 0, 0, 255, 255};
      4: v = '{1, 1, 0, 2, 1, 1, 2, 0};
      5: v = '{2, 1, 5, 0, 1, 0, 2, 0};
      6: v = '{3, 2, 0, 2, 1, 0, 3, 0};
      default: begin
        v[0] = ($urandom_range(3, 0) == 0) ? $urandom_range(127, 0) : $urandom_range(40, 1);
        ef = (v[0] > TRACKS) ? TRACKS : v[0];
        v[3] = $urandom_range(3, 0);
        for (int k = 0; k < 3; k++) begin
          v[1 + 3 * (k > 0) + 2 * (k > 1)] =
            (ef != 0 && $urandom_range(3, 0) != 0) ? $urandom_range(ef, 1)
                                                   : $urandom_range(255, 0);
          v[2 + 3 * (k > 0) + 2 * (k > 1)] =
            ($urandom_range(3, 0) != 0) ? $urandom_range(SPT - 1, 0) : $urandom_range(255, 0);
        end
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(cfg_idx_t'(i), v[i]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_tracks(input int smode);
    int                nload, ns, fc;
    logic [LBM_W-1:0]  bm, mask;
    nload = (book.tracks_in_use() == 0) ? 8 : book.tracks_in_use();
    for (int t = 1; t <= nload; t++) begin
      case (smode)
        0: ns = (t <= 17) ? 21 : (t <= 24) ? 19 : (t <= 30) ? 18 : 17;
        1: ns = $urandom_range(SPT, 0);
        default: ns = $urandom_range(4, 1);
      endcase
      mask = (24'd1 << ns) - 24'd1;
      case ($urandom_range(3, 0))
        0: bm = LBM_W'($urandom()) & mask;
        1: bm = LBM_W'($urandom());
        default: bm = mask;
      endcase
      fc = ($urandom_range(7, 0) == 0) ? $urandom_range(255, 0) : $countones(bm & mask);
      send_word(FN_LOAD, t, $urandom_range(255, 0), ns, fc, bm);
    end
  endtask

  task automatic mixed_ops(input int count);
    int               k, n, idx, at, as, ns, fc;
    logic [LBM_W-1:0] bm;
    repeat (count) begin
      n = book.tracks_in_use();
      k = $urandom_range(99, 0);
      if (k < 45) begin
        send_word(FN_ALLOC, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else if (k < 75) begin
        if (book.held.size() != 0 && $urandom_range(3, 0) != 0) begin
          idx = $urandom_range(book.held.size() - 1, 0);
          at = book.held[idx].trk;
          as = book.held[idx].sec;
          book.held.delete(idx);
        end else if ($urandom_range(1, 0) == 1) begin
          at = $urandom_range(n + 1, 0);
          as = $urandom_range(SPT + 1, 0);
        end else begin
          at = $urandom_range(255, 0);
          as = $urandom_range(255, 0);
        end
        send_word(FN_FREE, at, as, $urandom(), $urandom(), $urandom());
      end else if (k < 90) begin
        ns = ($urandom_range(4, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(SPT, 0);
        bm = LBM_W'($urandom());
        fc = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0)
                                         : $countones(bm & ((24'd1 << ns) - 24'd1));
        at = ($urandom_range(4, 0) == 0) ? $urandom_range(255, 0)
                                         : $urandom_range((n == 0) ? 1 : n, 1);
        send_word(FN_LOAD, at, $urandom(), ns, fc, bm);
      end else begin
        send_word(FN_SPARE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    int p;
    book = new();
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= CFG_NUM_TRACKS;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.func            <= FN_ALLOC;
    in_ch.trk             <= '0;
    in_ch.sec             <= '0;
    in_ch.load_sectors    <= '0;
    in_ch.load_free_count <= '0;
    in_ch.load_bitmap     <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct   = 10;
    stall_pct = 10;
    send_word(FN_ALLOC, 0, 0, 0, 0, 0);
    send_word(FN_FREE, 1, 0, 0, 0, 0);
    send_word(FN_LOAD, 0, 0, 24, 5, 'hFFFFFF);
    send_word(FN_LOAD, 71, 0, 24, 5, 'hFFFFFF);
    send_word(FN_LOAD, 255, 255, 24, 5, 'hFFFFFF);
    send_word(FN_LOAD, 1, 0, 25, 5, 'hFFFFFF);
    send_word(FN_LOAD, 2, 0, 31, 5, 'hFFFFFF);
    send_word(FN_LOAD, 1, 0, 24, 255, 'hFFFFFF);
    send_word(FN_LOAD, 70, 0, 24, 1, 'h800000);
    send_word(FN_LOAD, 18, 0, 19, 3, 'h000007);
    send_word(FN_ALLOC, 0, 0, 0, 0, 0);
    send_word(FN_FREE, 1, 0, 0, 0, 0);
    send_word(FN_FREE, 1, 0, 0, 0, 0);
    send_word(FN_FREE, 1, 24, 0, 0, 0);
    send_word(FN_FREE, 255, 255, 0, 0, 0);
    send_word(FN_FREE, 36, 0, 0, 0, 0);
    send_word(FN_FREE, 70, 23, 0, 0, 0);
    send_word(FN_SPARE, 255, 255, 31, 255, 'hFFFFFF);
    send_word(FN_LOAD, 1, 0, 24, 0, 'hFFFFFF);
    send_word(FN_ALLOC, 0, 0, 0, 0, 0);
    send_word(FN_ALLOC, 0, 0, 0, 0, 0);
    send_word(FN_FREE, 18, 1, 0, 0, 0);
    send_word(FN_FREE, 18, 0, 0, 0, 0);
    send_word(FN_LOAD, 2, 0, 1, 255, 0);
    send_word(FN_FREE, 2, 0, 0, 0, 0);
    send_word(FN_ALLOC, 0, 0, 0, 0, 0);

    p = 0;
    while (sent < ITEMS) begin
      if (ITEMS - sent < 200) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(2, 0))
          0: gap_pct = 0;
          1: gap_pct = 8;
          default: gap_pct = 30;
        endcase
        case ($urandom_range(2, 0))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
      set_geometry(p);
      load_tracks((p == 6) ? 2 : (p < 6) ? 0 : $urandom_range(2, 0));
      mixed_ops(80);
      p++;
    end

    drain_results();
    repeat (TAIL) @(posedge clk);
    if (book.faults == 0 && book.due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
